// ===== rtl/core/mtf_pkg.sv =====
`timescale 1ns / 1ps

package mtf_pkg;

   localparam int DEFAULT_CAPACITY    = 16;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   localparam int REQ_W   = 2;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   // request codes
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [VALUE_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0] front_value;
      logic               front_valid;
      logic               was_present;
      logic               evicted;
      logic               underflow;
      logic [COUNT_W-1:0] entry_count;
      logic               is_empty;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the accepted item
      logic match;    // register the compare vector
      logic update;   // apply the request, register the result
   } dp_cmd_type;

endpackage

// ===== rtl/core/mtf_controller.sv =====
`timescale 1ns / 1ps

module mtf_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output mtf_pkg::dp_cmd_type cmd,
   output logic                rsp_strobe
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MATCH  = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_MATCH;
         end
         ST_MATCH:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign strobe_in  = (state_ff == ST_UPDATE);
   assign busy       = (state_ff != ST_IDLE);
   assign cmd.load   = start && (state_ff == ST_IDLE);
   assign cmd.match  = (state_ff == ST_MATCH);
   assign cmd.update = (state_ff == ST_UPDATE);
   assign rsp_strobe = strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

endmodule

// ===== rtl/core/mtf_datapath.sv =====
`timescale 1ns / 1ps

module mtf_datapath #(
   parameter int CAPACITY    = mtf_pkg::DEFAULT_CAPACITY,
   parameter int VALUE_WIDTH = mtf_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mtf_pkg::dp_cmd_type   cmd,
   input  mtf_pkg::req_item_type req_item,
   output mtf_pkg::rsp_item_type rsp_item
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
   localparam logic [CAPACITY-1:0] ALL_ONES = '1;

   // list cells, front at index 0
   logic [VALUE_WIDTH-1:0] cell_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0] cell_in [CAPACITY];

   logic [mtf_pkg::REQ_W-1:0] op_ff;
   logic [VALUE_WIDTH-1:0]    val_ff;
   logic [63:0]               val_wide;

   logic [CAPACITY-1:0] match_ff, match_in;
   logic [CAPACITY-1:0] ahead;
   logic                hit, full, empty;

   logic [CW-1:0] occ_ff, occ_in;
   mtf_pkg::rsp_item_type rsp_ff, rsp_in;

   assign val_wide = 64'(req_item.value);

   // compare against every live cell
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = (CW'(i) < occ_ff) && (cell_ff[i] == val_ff);
      end
   end

   // ahead[i]: a match sits ahead of cell i, so cell i keeps its value
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         ahead[i] = |(match_ff & (ALL_ONES >> (CAPACITY - i)));
      end
   end

   assign hit   = |match_ff;
   assign full  = (occ_ff == FULL_COUNT);
   assign empty = (occ_ff == '0);

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) cell_in[i] = cell_ff[i];
      occ_in = occ_ff;
      rsp_in = '0;
      unique case (op_ff)
         mtf_pkg::REQ_INSERT: begin
            cell_in[0] = val_ff;
            for (int i = 1; i < CAPACITY; i++) begin
               if (!ahead[i]) cell_in[i] = cell_ff[i-1];
            end
            if (!hit && !full) occ_in = occ_ff + 1'b1;
            rsp_in.front_value = 32'(val_ff);
            rsp_in.front_valid = 1'b1;
            rsp_in.was_present = hit;
            rsp_in.evicted     = !hit && full;
         end
         mtf_pkg::REQ_REMOVE: begin
            if (empty) begin
               rsp_in.underflow = 1'b1;
            end else begin
               for (int i = 0; i < CAPACITY - 1; i++) cell_in[i] = cell_ff[i+1];
               occ_in = occ_ff - 1'b1;
               rsp_in.front_value = 32'(cell_ff[0]);
               rsp_in.front_valid = 1'b1;
            end
         end
         mtf_pkg::REQ_CLEAR: begin
            occ_in = '0;
         end
         default: begin
            if (!empty) begin
               rsp_in.front_value = 32'(cell_ff[0]);
               rsp_in.front_valid = 1'b1;
            end
         end
      endcase
      rsp_in.entry_count = mtf_pkg::COUNT_W'(occ_in);
      rsp_in.is_empty    = (occ_in == '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_item.req_type;
         val_ff <= val_wide[VALUE_WIDTH-1:0];
      end
      if (cmd.match) match_ff <= match_in;
      if (cmd.update) begin
         for (int i = 0; i < CAPACITY; i++) cell_ff[i] <= cell_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         rsp_ff <= '0;
      end else if (cmd.update) begin
         occ_ff <= occ_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item = rsp_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_COUNT)
      else $error("occupancy above capacity");

   a_underflow_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.update && (op_ff == mtf_pkg::REQ_REMOVE) && (occ_ff == '0)
      |=> (occ_ff == '0) && rsp_ff.underflow && !rsp_ff.front_valid)
      else $error("remove on empty list changed state");

   a_insert_flags: assert property (@(posedge clock) disable iff (reset)
      cmd.update && (op_ff == mtf_pkg::REQ_INSERT)
      |=> rsp_ff.front_valid && !(rsp_ff.was_present && rsp_ff.evicted)
          && !rsp_ff.is_empty)
      else $error("insert result flags inconsistent");

   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      cmd.update && (op_ff == mtf_pkg::REQ_INSERT) && !(|match_ff) && !full
      |=> occ_ff == CW'($past(occ_ff) + 1'b1))
      else $error("new value did not grow the list");

endmodule

// ===== rtl/core/move_to_front_recency_list.sv =====
`timescale 1ns / 1ps

// Move-to-front recency list.
// Holds up to CAPACITY distinct values, newest at the front.
// Request channel: an item (req_item) is taken at a rising edge with start
// high and busy low. Codes: insert/move-to-front, remove front, clear.
// Result channel: rsp_item is valid for exactly one cycle while rsp_strobe
// is high. The receiver cannot stall; every result must be taken then.
// Timing: an accepted item passes the match state and then the update
// state, with busy high in both, so a new item is taken only after the
// last one has been applied. The steps are: compare all live cells
// against the value (registered match vector), then apply the shift and
// register the result. The compare is parallel; the shift is one step.
// Reset clears the entry count, the result and the controller; cells are
// left as they are and are never read before written.
// Insert of a held value moves it to the front; insert into a full list
// drops the back entry (evicted). Remove on an empty list flags underflow.

module move_to_front_recency_list #(
   parameter int CAPACITY    = mtf_pkg::DEFAULT_CAPACITY,
   parameter int VALUE_WIDTH = mtf_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mtf_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output mtf_pkg::rsp_item_type rsp_item
);

   // command bundle from the sequencer to the datapath
   mtf_pkg::dp_cmd_type cmd;

   mtf_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   mtf_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

endmodule
